// File: rtl/sts_pkg.sv
package sts_pkg;

   // Offsets and queue sizing
   localparam int OFFSET_WIDTH = 32;
   localparam int FIELD_WIDTH  = 32;
   localparam int MAX_RESULTS  = 3;
   localparam int QUEUE_DEPTH  = 8;
   localparam int QUEUE_AW     = $clog2(QUEUE_DEPTH);
   localparam int LEVEL_W      = $clog2(QUEUE_DEPTH + 1);

   typedef logic [OFFSET_WIDTH-1:0] offset_type;
   typedef logic [FIELD_WIDTH-1:0]  field_type;

   // Token kinds as seen on the result channel
   typedef enum logic [3:0] {
      KIND_IDENT  = 4'd0,
      KIND_INT    = 4'd1,
      KIND_FLOAT  = 4'd2,
      KIND_DOT    = 4'd3,
      KIND_LPAR   = 4'd4,
      KIND_RPAR   = 4'd5,
      KIND_LCURLY = 4'd6,
      KIND_RCURLY = 4'd7,
      KIND_COLON  = 4'd8,
      KIND_COMMA  = 4'd9,
      KIND_STRING = 4'd10,
      KIND_OTHER  = 4'd11,
      KIND_ERROR  = 4'd12,
      KIND_END    = 4'd13
   } kind_type;

   typedef struct packed {
      kind_type  token_kind;
      field_type start_offset;
      field_type end_offset;
      logic      last_of_run;
   } token_type;

   // Tokens produced by one byte, written to the queue together
   typedef struct packed {
      logic [1:0]      count;
      token_type [2:0] tokens;
   } push_type;

   // Character constants
   localparam logic [7:0] CH_UNDERSCORE = "_";
   localparam logic [7:0] CH_X_LOW      = "x";
   localparam logic [7:0] CH_X_UP       = "X";
   localparam logic [7:0] CH_DOT        = ".";
   localparam logic [7:0] CH_E_LOW      = "e";
   localparam logic [7:0] CH_E_UP       = "E";
   localparam logic [7:0] CH_NEWLINE    = 8'h0A;
   localparam logic [7:0] CH_TAB        = 8'h09;
   localparam logic [7:0] CH_SPACE      = 8'h20;
   localparam logic [7:0] CH_STAR       = "*";
   localparam logic [7:0] CH_SLASH      = "/";
   localparam logic [7:0] CH_BACKSLASH  = 8'h5C;
   localparam logic [7:0] CH_SQUOTE     = 8'h27;
   localparam logic [7:0] CH_DQUOTE     = 8'h22;
   localparam logic [7:0] CH_LPAR       = "(";
   localparam logic [7:0] CH_RPAR       = ")";
   localparam logic [7:0] CH_LCURLY     = "{";
   localparam logic [7:0] CH_RCURLY     = "}";
   localparam logic [7:0] CH_COLON      = ":";
   localparam logic [7:0] CH_COMMA      = ",";

   function automatic logic is_digit(input logic [7:0] c);
      return (c >= "0") && (c <= "9");
   endfunction

   function automatic logic is_alpha(input logic [7:0] c);
      return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
   endfunction

   function automatic logic is_xdigit(input logic [7:0] c);
      return is_digit(c) || ((c >= "a") && (c <= "f")) || ((c >= "A") && (c <= "F"));
   endfunction

   function automatic logic is_ident_char(input logic [7:0] c);
      return is_alpha(c) || is_digit(c) || (c == CH_UNDERSCORE);
   endfunction

   // Low bits of an offset, zero-extended when the offset is narrower
   function automatic field_type to_field(input offset_type v);
      logic [OFFSET_WIDTH+FIELD_WIDTH-1:0] ext;
      ext = {{FIELD_WIDTH{1'b0}}, v};
      return ext[FIELD_WIDTH-1:0];
   endfunction

   function automatic token_type make_token(input kind_type k, input offset_type s,
                                            input offset_type e);
      token_type t;
      t.token_kind   = k;
      t.start_offset = to_field(s);
      t.end_offset   = to_field(e);
      t.last_of_run  = 1'b0;
      return t;
   endfunction

endpackage

// File: rtl/sts_if.sv
interface sts_req_if;
   import sts_pkg::*;
   logic       valid;
   logic       ready;
   logic [7:0] ch;
   logic       final_byte;
   modport source (output valid, output ch, output final_byte, input ready);
   modport sink (input valid, input ch, input final_byte, output ready);
endinterface

interface sts_rsp_if;
   import sts_pkg::*;
   logic       valid;
   logic       ready;
   logic [3:0] token_kind;
   field_type  start_offset;
   field_type  end_offset;
   logic       last_of_run;
   modport source (output valid, output token_kind, output start_offset, output end_offset,
                   output last_of_run, input ready);
   modport sink (input valid, input token_kind, input start_offset, input end_offset,
                 input last_of_run, output ready);
endinterface

// File: rtl/sts_core.sv
module sts_core
   import sts_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       accept,
   input  logic [7:0] ch,
   input  logic       final_byte,
   output push_type   push
);

   typedef enum logic [3:0] {
      MODE_IDLE       = 4'd0,
      MODE_IDENT      = 4'd1,
      MODE_NUM_FIRST  = 4'd2,
      MODE_HEX        = 4'd3,
      MODE_DEC        = 4'd4,
      MODE_FRAC       = 4'd5,
      MODE_EXP        = 4'd6,
      MODE_DOT        = 4'd7,
      MODE_SLASH      = 4'd8,
      MODE_LINE_CMT   = 4'd9,
      MODE_BLOCK_CMT  = 4'd10,
      MODE_BLOCK_STAR = 4'd11,
      MODE_STRING     = 4'd12,
      MODE_STRING_ESC = 4'd13
   } mode_type;

   logic       valid_ff;
   logic [7:0] ch_ff;
   logic       final_ff;

   mode_type   mode_ff, mode_in;
   offset_type pos_ff, pos_in;
   offset_type start_ff, start_in;
   logic       dquote_ff, dquote_in;

   offset_type      nxt;
   logic            do_close;
   kind_type        close_kind;
   logic            redo;
   logic [1:0]      n;
   token_type [2:0] toks;

   // Register the accepted word
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= accept;
      end
      if (accept) begin
         ch_ff    <= ch;
         final_ff <= final_byte;
      end
   end

   // Scan state
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_IDLE;
         pos_ff    <= '0;
         start_ff  <= '0;
         dquote_ff <= 1'b0;
      end else begin
         mode_ff   <= mode_in;
         pos_ff    <= pos_in;
         start_ff  <= start_in;
         dquote_ff <= dquote_in;
      end
   end

   // Advance the scanner by one byte and collect its tokens
   always_comb begin
      mode_in    = mode_ff;
      pos_in     = pos_ff;
      start_in   = start_ff;
      dquote_in  = dquote_ff;
      nxt        = (pos_ff == '1) ? pos_ff : pos_ff + 1'b1;
      do_close   = 1'b0;
      close_kind = KIND_OTHER;
      redo       = 1'b0;
      n          = '0;
      toks       = '0;

      if (valid_ff) begin
         case (mode_ff)
            MODE_IDENT: begin
               if (!is_ident_char(ch_ff)) begin
                  do_close = 1'b1; close_kind = KIND_IDENT;
               end
            end
            MODE_NUM_FIRST: begin
               if ((ch_ff == CH_X_LOW) || (ch_ff == CH_X_UP)) mode_in = MODE_HEX;
               else if (is_digit(ch_ff)) mode_in = MODE_DEC;
               else if (ch_ff == CH_DOT) mode_in = MODE_FRAC;
               else begin
                  do_close = 1'b1; close_kind = KIND_INT;
               end
            end
            MODE_HEX: begin
               if (!is_xdigit(ch_ff)) begin
                  do_close = 1'b1; close_kind = KIND_INT;
               end
            end
            MODE_DEC: begin
               if (ch_ff == CH_DOT) mode_in = MODE_FRAC;
               else if (!is_digit(ch_ff)) begin
                  do_close = 1'b1; close_kind = KIND_INT;
               end
            end
            MODE_FRAC: begin
               if ((ch_ff == CH_E_LOW) || (ch_ff == CH_E_UP)) mode_in = MODE_EXP;
               else if (!is_digit(ch_ff)) begin
                  do_close = 1'b1; close_kind = KIND_FLOAT;
               end
            end
            MODE_EXP: begin
               if (!is_digit(ch_ff)) begin
                  do_close = 1'b1; close_kind = KIND_FLOAT;
               end
            end
            MODE_DOT: begin
               if (is_digit(ch_ff)) mode_in = MODE_FRAC;
               else begin
                  do_close = 1'b1; close_kind = KIND_DOT;
               end
            end
            MODE_SLASH: begin
               if (ch_ff == CH_SLASH) mode_in = MODE_LINE_CMT;
               else if (ch_ff == CH_STAR) mode_in = MODE_BLOCK_CMT;
               else begin
                  do_close = 1'b1; close_kind = KIND_OTHER;
               end
            end
            MODE_LINE_CMT: begin
               if (ch_ff == CH_NEWLINE) mode_in = MODE_IDLE;
            end
            MODE_BLOCK_CMT: begin
               if (ch_ff == CH_STAR) mode_in = MODE_BLOCK_STAR;
            end
            MODE_BLOCK_STAR: begin
               if (ch_ff == CH_SLASH) mode_in = MODE_IDLE;
               else if (ch_ff != CH_STAR) mode_in = MODE_BLOCK_CMT;
            end
            MODE_STRING: begin
               if (ch_ff == CH_BACKSLASH) mode_in = MODE_STRING_ESC;
               else if ((dquote_ff && (ch_ff == CH_DQUOTE)) ||
                        (!dquote_ff && (ch_ff == CH_SQUOTE))) begin
                  toks[n] = make_token(KIND_STRING, start_ff, nxt);
                  n = n + 1'b1;
                  mode_in = MODE_IDLE;
               end
            end
            MODE_STRING_ESC: begin
               mode_in = MODE_STRING;
            end
            default: begin
               redo = 1'b1;
            end
         endcase

         // Close the pending token at this byte, then rescan the byte from idle
         if (do_close) begin
            toks[n] = make_token(close_kind, start_ff, pos_ff);
            n = n + 1'b1;
            redo = 1'b1;
         end

         if (redo) begin
            mode_in  = MODE_IDLE;
            start_in = pos_ff;
            if (is_alpha(ch_ff) || (ch_ff == CH_UNDERSCORE)) mode_in = MODE_IDENT;
            else if (is_digit(ch_ff)) mode_in = MODE_NUM_FIRST;
            else begin
               case (ch_ff)
                  CH_DOT:   mode_in = MODE_DOT;
                  CH_SLASH: mode_in = MODE_SLASH;
                  CH_LPAR: begin
                     toks[n] = make_token(KIND_LPAR, pos_ff, nxt); n = n + 1'b1;
                  end
                  CH_RPAR: begin
                     toks[n] = make_token(KIND_RPAR, pos_ff, nxt); n = n + 1'b1;
                  end
                  CH_LCURLY: begin
                     toks[n] = make_token(KIND_LCURLY, pos_ff, nxt); n = n + 1'b1;
                  end
                  CH_RCURLY: begin
                     toks[n] = make_token(KIND_RCURLY, pos_ff, nxt); n = n + 1'b1;
                  end
                  CH_COLON: begin
                     toks[n] = make_token(KIND_COLON, pos_ff, nxt); n = n + 1'b1;
                  end
                  CH_COMMA: begin
                     toks[n] = make_token(KIND_COMMA, pos_ff, nxt); n = n + 1'b1;
                  end
                  CH_SPACE, CH_TAB, CH_NEWLINE: begin
                  end
                  CH_SQUOTE, CH_DQUOTE: begin
                     dquote_in = (ch_ff == CH_DQUOTE);
                     mode_in   = MODE_STRING;
                  end
                  default: begin
                     toks[n] = make_token(KIND_OTHER, pos_ff, nxt); n = n + 1'b1;
                  end
               endcase
            end
         end

         // Flush at end of text, then emit the end marker
         if (final_ff) begin
            case (mode_in)
               MODE_IDENT: begin
                  toks[n] = make_token(KIND_IDENT, start_in, nxt); n = n + 1'b1;
               end
               MODE_NUM_FIRST, MODE_HEX, MODE_DEC: begin
                  toks[n] = make_token(KIND_INT, start_in, nxt); n = n + 1'b1;
               end
               MODE_FRAC, MODE_EXP: begin
                  toks[n] = make_token(KIND_FLOAT, start_in, nxt); n = n + 1'b1;
               end
               MODE_DOT: begin
                  toks[n] = make_token(KIND_DOT, start_in, nxt); n = n + 1'b1;
               end
               MODE_SLASH: begin
                  toks[n] = make_token(KIND_OTHER, start_in, nxt); n = n + 1'b1;
               end
               MODE_BLOCK_CMT, MODE_BLOCK_STAR, MODE_STRING, MODE_STRING_ESC: begin
                  toks[n] = make_token(KIND_ERROR, start_in, nxt); n = n + 1'b1;
               end
               default: begin
               end
            endcase
            toks[n]  = make_token(KIND_END, nxt, nxt);
            n        = n + 1'b1;
            mode_in  = MODE_IDLE;
            pos_in   = '0;
            start_in = '0;
         end else begin
            pos_in = nxt;
         end

         // Flag the final token of this byte
         for (int i = 0; i < MAX_RESULTS; i++) begin
            toks[i].last_of_run = (n == 2'(i + 1));
         end
      end
   end

   assign push.count  = n;
   assign push.tokens = toks;

endmodule

// File: rtl/sts_queue.sv
module sts_queue
   import sts_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  push_type           push,
   input  logic               pop,
   output token_type          head,
   output logic [LEVEL_W-1:0] level
);

   token_type             mem [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0]   head_ff, tail_ff;
   logic [LEVEL_W-1:0]    level_ff;

   // Advance pointers and fill level
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         level_ff <= '0;
      end else begin
         tail_ff  <= tail_ff + QUEUE_AW'(push.count);
         head_ff  <= head_ff + QUEUE_AW'(pop);
         level_ff <= level_ff + LEVEL_W'(push.count) - LEVEL_W'(pop);
      end
   end

   // Write up to three words at the tail
   always_ff @(posedge clock) begin
      for (int i = 0; i < MAX_RESULTS; i++) begin
         if (2'(i) < push.count) begin
            mem[tail_ff + QUEUE_AW'(i)] <= push.tokens[i];
         end
      end
   end

   assign head  = mem[head_ff];
   assign level = level_ff;

endmodule

// File: rtl/source_token_scanner.sv
// A taken byte is registered in the core, and its tokens are then written to the result queue
// and leave on rsp_bus from the head of that queue.
// Throughput: one byte per cycle while the eight-word result queue has room; req_bus.ready
// drops when queued tokens plus those being written exceed five (room for three more).
// A byte gives zero to three tokens; the queue's single read port drains one per cycle while rsp_bus.ready is high.
// Reset (synchronous, active high) empties the queue, holds req_bus.ready low and returns
// the scanner to idle at offset zero.
module source_token_scanner
   import sts_pkg::*;
(
   input logic     clock,
   input logic     reset,
   sts_req_if.sink   req_bus,
   sts_rsp_if.source rsp_bus
);

   push_type           push;
   token_type          head;
   logic [LEVEL_W-1:0] level;
   logic [LEVEL_W:0]   level_sum;
   logic               accept;
   logic               pop;

   // Accept only while the queue has room for the byte in flight and this one
   assign level_sum     = {1'b0, level} + (LEVEL_W + 1)'(push.count);
   assign req_bus.ready = !reset &&
                          (level_sum <= (LEVEL_W + 1)'(QUEUE_DEPTH - MAX_RESULTS));
   assign accept        = req_bus.valid & req_bus.ready;
   assign pop           = rsp_bus.valid & rsp_bus.ready;

   sts_core u_core (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .ch         (req_bus.ch),
      .final_byte (req_bus.final_byte),
      .push       (push)
   );

   sts_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .pop   (pop),
      .head  (head),
      .level (level)
   );

   assign rsp_bus.valid        = (level != '0);
   assign rsp_bus.token_kind   = head.token_kind;
   assign rsp_bus.start_offset = head.start_offset;
   assign rsp_bus.end_offset   = head.end_offset;
   assign rsp_bus.last_of_run  = head.last_of_run;

endmodule

// File: rtl/sts_checker.sv
module sts_checker
   import sts_pkg::*;
(
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [3:0] rsp_kind,
   input field_type  rsp_start,
   input field_type  rsp_end,
   input logic       rsp_last
);

   // Hold a stalled word
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result word dropped while stalled");

   // End marker is empty and closes its byte's run
   a_end_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind == KIND_END) |-> (rsp_start == rsp_end) && rsp_last)
      else $error("malformed end marker");

   // Tokens never run backward
   a_span_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_start <= rsp_end)
      else $error("token ends before it starts");

   // A string token is never empty
   a_string_len: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind == KIND_STRING) |-> rsp_start != rsp_end)
      else $error("empty string token");

endmodule

bind source_token_scanner sts_checker u_sts_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_bus.valid),
   .rsp_ready (rsp_bus.ready),
   .rsp_kind  (rsp_bus.token_kind),
   .rsp_start (rsp_bus.start_offset),
   .rsp_end   (rsp_bus.end_offset),
   .rsp_last  (rsp_bus.last_of_run)
);

// File: test/tb.sv
`timescale 1ns / 1ps

module tb;
   import sts_pkg::*;

   typedef enum logic [3:0] {
      MODE_IDLE,
      MODE_IDENT,
      MODE_NUM_FIRST,
      MODE_HEX,
      MODE_DEC,
      MODE_FRAC,
      MODE_EXP,
      MODE_DOT,
      MODE_SLASH,
      MODE_LINE_CMT,
      MODE_BLOCK_CMT,
      MODE_BLOCK_STAR,
      MODE_STRING,
      MODE_STRING_ESC
   } scan_mode_type;

   typedef enum {
      PHASE_CALM,
      PHASE_SENDER_IDLE,
      PHASE_RECEIVER_STALL,
      PHASE_BOTH_IDLE,
      PHASE_PRESSURE
   } run_phase_type;

   typedef struct {
      logic [7:0] ch;
      logic       final_byte;
   } source_byte_type;

   localparam int HOLD_CYCLES = 150;

   logic clock = 1'b0;
   logic reset = 1'b1;

   sts_req_if req_if ();
   sts_rsp_if rsp_if ();

   source_token_scanner i_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_if),
      .rsp_bus (rsp_if)
   );

   // Scanner state mirrored by the predictor
   scan_mode_type scan_mode = MODE_IDLE;
   offset_type    scan_pos  = '0;
   offset_type    tok_start = '0;
   logic          quote_dbl = 1'b0;
   token_type     run_tokens[$];

   token_type       pending_tokens[$];
   source_byte_type source_bytes[$];
   logic [7:0]      text_buf[$];
   source_byte_type drive_byte;
   token_type       got_token;
   token_type       want_token;

   run_phase_type run_phase     = PHASE_CALM;
   int unsigned   send_idle_pct = 0;
   int unsigned   stall_pct     = 0;
   int unsigned   hold_left     = 0;
   logic          hold_done     = 1'b0;

   int unsigned errors        = 0;
   int unsigned bytes_scanned = 0;
   int unsigned texts_scanned = 0;
   int unsigned tokens_seen   = 0;
   int unsigned input_held    = 0;
   logic [13:0] kinds_seen    = '0;

   always #5 clock = ~clock;

   initial begin
      req_if.valid      = 1'b0;
      req_if.ch         = '0;
      req_if.final_byte = 1'b0;
      rsp_if.ready      = 1'b0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
   end

   // Character classes, ASCII only
   function automatic logic digit_ch(logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   function automatic logic alpha_ch(logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
   endfunction

   function automatic logic hex_ch(logic [7:0] c);
      return digit_ch(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
   endfunction

   function automatic logic word_ch(logic [7:0] c);
      return alpha_ch(c) || digit_ch(c) || c == CH_UNDERSCORE;
   endfunction

   function automatic offset_type sat_next(offset_type v);
      return (v == '1) ? v : v + 1'b1;
   endfunction

   function void add_token(kind_type k, offset_type s, offset_type e);
      token_type t;
      if (run_tokens.size() >= MAX_RESULTS) return;
      t.token_kind   = k;
      t.start_offset = s;
      t.end_offset   = e;
      t.last_of_run  = 1'b0;
      run_tokens.push_back(t);
   endfunction

   // Handle a byte from the idle mode: start a token, skip white space or emit a one-byte one
   function void start_fresh(logic [7:0] c, offset_type p);
      offset_type n;
      n = sat_next(p);
      tok_start = p;
      scan_mode = MODE_IDLE;
      if (alpha_ch(c) || c == CH_UNDERSCORE) scan_mode = MODE_IDENT;
      else if (digit_ch(c)) scan_mode = MODE_NUM_FIRST;
      else begin
         case (c)
            CH_DOT:                         scan_mode = MODE_DOT;
            CH_SLASH:                       scan_mode = MODE_SLASH;
            CH_LPAR:                        add_token(KIND_LPAR, p, n);
            CH_RPAR:                        add_token(KIND_RPAR, p, n);
            CH_LCURLY:                      add_token(KIND_LCURLY, p, n);
            CH_RCURLY:                      add_token(KIND_RCURLY, p, n);
            CH_COLON:                       add_token(KIND_COLON, p, n);
            CH_COMMA:                       add_token(KIND_COMMA, p, n);
            CH_SPACE, CH_TAB, CH_NEWLINE:   ;
            CH_SQUOTE, CH_DQUOTE: begin
               quote_dbl = (c == CH_DQUOTE);
               scan_mode = MODE_STRING;
            end
            default:                        add_token(KIND_OTHER, p, n);
         endcase
      end
   endfunction

   // Close the pending token at the lookahead byte, then handle that byte
   function void close_token(kind_type k, logic [7:0] c, offset_type p);
      add_token(k, tok_start, p);
      start_fresh(c, p);
   endfunction

   // Work out the tokens one byte causes and queue them for checking
   function void predict_tokens(logic [7:0] c, logic fin);
      offset_type p;
      offset_type n;
      token_type  t;
      p = scan_pos;
      n = sat_next(p);
      run_tokens.delete();
      case (scan_mode)
         MODE_IDENT:
            if (!word_ch(c)) close_token(KIND_IDENT, c, p);
         MODE_NUM_FIRST:
            if (c == CH_X_LOW || c == CH_X_UP) scan_mode = MODE_HEX;
            else if (digit_ch(c)) scan_mode = MODE_DEC;
            else if (c == CH_DOT) scan_mode = MODE_FRAC;
            else close_token(KIND_INT, c, p);
         MODE_HEX:
            if (!hex_ch(c)) close_token(KIND_INT, c, p);
         MODE_DEC:
            if (c == CH_DOT) scan_mode = MODE_FRAC;
            else if (!digit_ch(c)) close_token(KIND_INT, c, p);
         MODE_FRAC:
            if (c == CH_E_LOW || c == CH_E_UP) scan_mode = MODE_EXP;
            else if (!digit_ch(c)) close_token(KIND_FLOAT, c, p);
         MODE_EXP:
            if (!digit_ch(c)) close_token(KIND_FLOAT, c, p);
         MODE_DOT:
            if (digit_ch(c)) scan_mode = MODE_FRAC;
            else close_token(KIND_DOT, c, p);
         MODE_SLASH:
            if (c == CH_SLASH) scan_mode = MODE_LINE_CMT;
            else if (c == CH_STAR) scan_mode = MODE_BLOCK_CMT;
            else close_token(KIND_OTHER, c, p);
         MODE_LINE_CMT:
            if (c == CH_NEWLINE) scan_mode = MODE_IDLE;
         MODE_BLOCK_CMT:
            if (c == CH_STAR) scan_mode = MODE_BLOCK_STAR;
         MODE_BLOCK_STAR:
            if (c == CH_SLASH) scan_mode = MODE_IDLE;
            else if (c != CH_STAR) scan_mode = MODE_BLOCK_CMT;
         MODE_STRING:
            if (c == CH_BACKSLASH) scan_mode = MODE_STRING_ESC;
            else if (c == (quote_dbl ? CH_DQUOTE : CH_SQUOTE)) begin
               add_token(KIND_STRING, tok_start, n);
               scan_mode = MODE_IDLE;
            end
         MODE_STRING_ESC:
            scan_mode = MODE_STRING;
         default:
            start_fresh(c, p);
      endcase

      // Flush at end of text, then the end marker; restart at offset zero
      if (fin) begin
         case (scan_mode)
            MODE_IDENT:                           add_token(KIND_IDENT, tok_start, n);
            MODE_NUM_FIRST, MODE_HEX, MODE_DEC:   add_token(KIND_INT, tok_start, n);
            MODE_FRAC, MODE_EXP:                  add_token(KIND_FLOAT, tok_start, n);
            MODE_DOT:                             add_token(KIND_DOT, tok_start, n);
            MODE_SLASH:                           add_token(KIND_OTHER, tok_start, n);
            MODE_BLOCK_CMT, MODE_BLOCK_STAR, MODE_STRING, MODE_STRING_ESC:
                                                  add_token(KIND_ERROR, tok_start, n);
            default:                              ;
         endcase
         add_token(KIND_END, n, n);
         scan_mode = MODE_IDLE;
         scan_pos  = '0;
         tok_start = '0;
      end else begin
         scan_pos = n;
      end

      // Mark the last token of this byte
      if (run_tokens.size() != 0) begin
         t = run_tokens.pop_back();
         t.last_of_run = 1'b1;
         run_tokens.push_back(t);
      end
      foreach (run_tokens[i]) pending_tokens.push_back(run_tokens[i]);
   endfunction

   // Drive source bytes; hold the word until it is taken
   always @(posedge clock) begin
      if (reset) begin
         req_if.valid      <= 1'b0;
         req_if.ch         <= '0;
         req_if.final_byte <= 1'b0;
      end else if (!req_if.valid || req_if.ready) begin
         if (source_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            drive_byte = source_bytes.pop_front();
            req_if.valid      <= 1'b1;
            req_if.ch         <= drive_byte.ch;
            req_if.final_byte <= drive_byte.final_byte;
         end else begin
            req_if.valid <= 1'b0;
         end
      end
   end

   // Stall the result side at random; hold off for a long stretch once under pressure
   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else if (hold_left != 0) begin
         rsp_if.ready <= 1'b0;
         hold_left    <= hold_left - 1;
      end else if (run_phase == PHASE_PRESSURE && !hold_done) begin
         rsp_if.ready <= 1'b0;
         hold_left    <= HOLD_CYCLES;
         hold_done    <= 1'b1;
      end else begin
         rsp_if.ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   // Predict on each accepted byte, then check each accepted token
   always @(posedge clock) begin
      if (!reset) begin
         if (req_if.valid && req_if.ready) begin
            predict_tokens(req_if.ch, req_if.final_byte);
            bytes_scanned++;
            if (req_if.final_byte) texts_scanned++;
         end else if (req_if.valid) begin
            input_held++;
         end

         if (rsp_if.valid && rsp_if.ready) begin
            got_token.token_kind   = kind_type'(rsp_if.token_kind);
            got_token.start_offset = rsp_if.start_offset;
            got_token.end_offset   = rsp_if.end_offset;
            got_token.last_of_run  = rsp_if.last_of_run;
            tokens_seen++;
            if (pending_tokens.size() == 0) begin
               errors++;
               $display("%0t: unexpected token: kind %0d start %0d end %0d last %0d", $time,
                        got_token.token_kind, got_token.start_offset, got_token.end_offset,
                        got_token.last_of_run);
            end else begin
               want_token = pending_tokens.pop_front();
               kinds_seen[want_token.token_kind] = 1'b1;
               if (got_token !== want_token) begin
                  errors++;
                  $display("%0t: token mismatch: expected kind %0d start %0d end %0d last %0d",
                           $time, want_token.token_kind, want_token.start_offset,
                           want_token.end_offset, want_token.last_of_run);
                  $display("%0t:                 actual   kind %0d start %0d end %0d last %0d",
                           $time, got_token.token_kind, got_token.start_offset,
                           got_token.end_offset, got_token.last_of_run);
               end
            end
         end
      end
   end

   function automatic logic [7:0] pick(string set);
      return set[$urandom_range(set.len() - 1)];
   endfunction

   function void push_text(string s);
      for (int i = 0; i < s.len(); i++) text_buf.push_back(s[i]);
   endfunction

   // Move the built text to the driver queue, final flag on its last byte
   function void flush_text();
      source_byte_type b;
      foreach (text_buf[i]) begin
         b.ch         = text_buf[i];
         b.final_byte = (i == text_buf.size() - 1);
         source_bytes.push_back(b);
      end
      text_buf.delete();
   endfunction

   // Append one lexical fragment with random content
   function void add_fragment();
      logic [7:0] q;
      logic [7:0] c;
      case ($urandom_range(11))
         0: begin
            text_buf.push_back(pick("abcxyzABCXYZeE_"));
            repeat ($urandom_range(6)) text_buf.push_back(pick("abqzAQZ_0189xXeE"));
         end
         1: repeat ($urandom_range(1, 5)) text_buf.push_back(pick("0123456789"));
         2: begin
            text_buf.push_back("0");
            text_buf.push_back(pick("xX"));
            repeat ($urandom_range(4)) text_buf.push_back(pick("0189afAFgG"));
         end
         3: begin
            repeat ($urandom_range(1, 3)) text_buf.push_back(pick("0123456789"));
            text_buf.push_back(CH_DOT);
            repeat ($urandom_range(3)) text_buf.push_back(pick("0123456789"));
            if ($urandom_range(1)) begin
               text_buf.push_back(pick("eE"));
               repeat ($urandom_range(3)) text_buf.push_back(pick("0123456789"));
            end
         end
         4: begin
            text_buf.push_back(CH_DOT);
            repeat ($urandom_range(2)) text_buf.push_back(pick("0123456789"));
         end
         5: text_buf.push_back(pick("(){}:,"));
         6: begin
            q = $urandom_range(1) ? CH_DQUOTE : CH_SQUOTE;
            text_buf.push_back(q);
            repeat ($urandom_range(6)) begin
               c = ($urandom_range(7) == 0) ? 8'($urandom_range(128, 255))
                                            : 8'($urandom_range(32, 126));
               if (c == q || c == CH_BACKSLASH || $urandom_range(7) == 0)
                  text_buf.push_back(CH_BACKSLASH);
               text_buf.push_back(c);
            end
            text_buf.push_back(q);
         end
         7: repeat ($urandom_range(1, 3)) text_buf.push_back(pick(" \t\n"));
         8: begin
            push_text("//");
            repeat ($urandom_range(5)) text_buf.push_back(8'($urandom_range(13, 255)));
            text_buf.push_back(CH_NEWLINE);
         end
         9: begin
            push_text("/*");
            repeat ($urandom_range(5)) begin
               c = pick("ab* \n/");
               if (c == CH_SLASH && text_buf[$] == CH_STAR) c = "a";
               text_buf.push_back(c);
            end
            repeat ($urandom_range(1, 2)) text_buf.push_back(CH_STAR);
            text_buf.push_back(CH_SLASH);
         end
         10: text_buf.push_back(8'($urandom_range(255)));
         default: text_buf.push_back(CH_SPACE);
      endcase
   endfunction

   // Queue random texts, some ending inside a comment, string or after a slash
   function void queue_random_texts(int unsigned count);
      int unsigned queued;
      queued = 0;
      while (queued < count) begin
         repeat ($urandom_range(2, 12)) add_fragment();
         if ($urandom_range(5) == 0) begin
            case ($urandom_range(4))
               0: push_text("/*a");
               1: push_text("\"a");
               2: push_text("'\\");
               3: push_text("//");
               default: push_text("/");
            endcase
         end
         queued += text_buf.size();
         flush_text();
      end
   endfunction

   task set_phase(run_phase_type p);
      @(negedge clock);
      run_phase = p;
      case (p)
         PHASE_SENDER_IDLE:    begin send_idle_pct = 80; stall_pct = 0;  end
         PHASE_RECEIVER_STALL: begin send_idle_pct = 0;  stall_pct = 80; end
         PHASE_BOTH_IDLE:      begin send_idle_pct = 8;  stall_pct = 8;  end
         default:              begin send_idle_pct = 0;  stall_pct = 0;  end
      endcase
   endtask

   // Check at falling edges, once every update of the rising edge has settled
   task wait_drained();
      do begin
         @(negedge clock);
      end while (!(source_bytes.size() == 0 && !req_if.valid &&
                   pending_tokens.size() == 0));
   endtask

   // Stimulus: directed texts, then random texts phase by phase
   initial begin
      wait (!reset);
      set_phase(PHASE_CALM);

      // brackets, colon, comma, an identifier, hex with no digits, a lone dot, a fraction from a dot
      push_text("(_a:0x,.5e3{.})");
      flush_text();
      // escaped quote, byte right after a block comment, end inside a string
      push_text("'\\''/**/\"x");
      flush_text();
      // control bytes, high byte, slash as other, end inside a line comment
      text_buf.push_back(8'h00);
      text_buf.push_back(8'h0D);
      text_buf.push_back(CH_SLASH);
      text_buf.push_back(8'hFF);
      push_text("//");
      flush_text();
      // end inside a block comment
      push_text("/*");
      flush_text();
      wait_drained();

      queue_random_texts(60);
      wait_drained();
      set_phase(PHASE_SENDER_IDLE);
      queue_random_texts(60);
      wait_drained();
      set_phase(PHASE_RECEIVER_STALL);
      queue_random_texts(60);
      wait_drained();
      set_phase(PHASE_BOTH_IDLE);
      queue_random_texts(60);
      wait_drained();

      // one token per byte, plus the end marker, while the result side holds off
      set_phase(PHASE_PRESSURE);
      repeat (60) text_buf.push_back(pick("(){}:,"));
      flush_text();
      wait_drained();

      repeat (10) @(posedge clock);
      $display("Scanned %0d bytes in %0d texts; checked %0d tokens covering %0d of 14 kinds.",
               bytes_scanned, texts_scanned, tokens_seen, $countones(kinds_seen));
      $display("Input was held back on %0d cycles while results backed up.", input_held);
      if (errors == 0 && pending_tokens.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("Timeout with %0d tokens still expected.", pending_tokens.size());
      $display("CHECK FAILED");
      $finish;
   end

endmodule
